>>> sv/evhp_pkg.sv
// Shared types and constants for the Ethernet VLAN header parser.
package evhp_pkg;

    localparam int unsigned CfgIndexWidth = 1;
    localparam int unsigned CfgDataWidth  = 16;

    localparam logic [15:0] PortTpidReset = 16'h8100;
    localparam logic [15:0] StagTpidReset = 16'h88A8;
    localparam logic [15:0] Tpid8021q     = 16'h8100;
    localparam logic [15:0] LlcLimit      = 16'd1536;

    localparam logic [4:0] HdrLenUntagged = 5'd14;
    localparam logic [4:0] HdrLenSingle   = 5'd18;
    localparam logic [4:0] HdrLenDouble   = 5'd22;
    localparam logic [4:0] PosMax         = 5'd31;

    typedef enum logic [CfgIndexWidth-1:0] {
        REG_PORT_TPID = 1'b0,
        REG_STAG_TPID = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        STATUS_OK            = 2'd0,
        STATUS_SHORT_HEADER  = 2'd1,
        STATUS_SHORT_PAYLOAD = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        TAGS_NONE   = 2'd0,
        TAGS_SINGLE = 2'd1,
        TAGS_DOUBLE = 2'd2
    } tag_count_t;

    typedef struct packed {
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [15:0] ether_type;
        logic [7:0]  sub_type;
        logic [11:0] outer_vid;
        logic [2:0]  priority_res;
        logic [15:0] outer_tpid;
        logic [11:0] inner_vid;
        logic [15:0] inner_tpid;
        logic [4:0]  header_length;
        status_t     status;
    } result_t;

endpackage

>>> sv/ethernet_vlan_header_parser.sv
// Ethernet header parser with 802.1Q and QinQ tag extraction, one byte per cycle.
//
// Usage: frame bytes enter in wire order on the byte channel (byte_valid,
// byte_ready, data_byte, last_byte), last_byte marking the final byte.
// One result transfer is made per frame on the result channel once the
// header and the payload bytes needed for the subtype have arrived, or at
// the last byte if the frame ends first; status then flags a short header
// or missing payload bytes. Bytes after the result are dropped until the
// last byte, which starts a new frame.
// The result is registered and appears in the cycle after the
// transfer of the byte that completes it.
// Throughput: one byte per cycle. Each byte updates the registered parse state
// when it is accepted; the only stall comes from the result register.
// If the receiver holds result_ready low, the result waits in its register
// and byte_ready drops only while that register is full and not draining.
// Reset clears the parse state, empties the result register and loads the
// TPID registers with 0x8100 (port) and 0x88A8 (service tag).
// The TPID registers are written through cfg_write/cfg_index/cfg_data; the user must write
// them only while no frame is in flight, as the block itself does not enforce it.
module ethernet_vlan_header_parser
    import evhp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data,
    input  logic                     byte_valid,
    output logic                     byte_ready,
    input  logic [7:0]               data_byte,
    input  logic                     last_byte,
    output logic                     result_valid,
    input  logic                     result_ready,
    output logic [47:0]              dest_mac,
    output logic [47:0]              source_mac,
    output logic [15:0]              ether_type,
    output logic [7:0]               sub_type,
    output logic [11:0]              outer_vid,
    output logic [2:0]               priority_res,
    output logic [15:0]              outer_tpid,
    output logic [11:0]              inner_vid,
    output logic [15:0]              inner_tpid,
    output logic [4:0]               header_length,
    output logic [1:0]               status
);

    logic [15:0] port_tpid_reg;
    logic [15:0] stag_tpid_reg;

    logic [4:0]  pos_reg,        pos_next;
    logic        sent_reg,       sent_next;
    logic [47:0] dest_reg,       dest_next;
    logic [47:0] source_reg,     source_next;
    logic [15:0] type_reg,       type_next;
    logic [15:0] otci_reg,       otci_next;
    logic [15:0] otpid_reg,      otpid_next;
    logic [15:0] itci_reg,       itci_next;
    logic [15:0] itpid_reg,      itpid_next;
    tag_count_t  tags_reg,       tags_next;
    logic [23:0] payload_reg,    payload_next;

    logic        out_valid_reg;
    result_t     result_reg,     result_next;

    logic        accept;
    logic        emit;
    logic [4:0]  hdr_len;
    logic [5:0]  pos_plus;
    logic [5:0]  got;
    logic        llc;
    logic        got_enough;
    logic [23:0] payload_full;

    assign byte_ready = !out_valid_reg || result_ready;
    assign accept     = byte_valid && byte_ready;
    assign pos_plus   = {1'b0, pos_reg} + 6'd1;

    always_comb
    begin
        pos_next     = pos_reg;
        sent_next    = sent_reg;
        dest_next    = dest_reg;
        source_next  = source_reg;
        type_next    = type_reg;
        otci_next    = otci_reg;
        otpid_next   = otpid_reg;
        itci_next    = itci_reg;
        itpid_next   = itpid_reg;
        tags_next    = tags_reg;
        payload_next = payload_reg;
        emit         = 1'b0;
        hdr_len      = HdrLenUntagged;
        got          = '0;
        llc          = 1'b0;
        got_enough   = 1'b0;
        payload_full = '0;
        result_next  = '0;
        result_next.header_length = HdrLenUntagged;
        result_next.status        = STATUS_OK;

        if (accept)
        begin
            if (!sent_reg)
            begin
                // Route the byte to the header field that owns this position.
                if (pos_reg < 5'd6)
                begin
                    dest_next = {dest_reg[39:0], data_byte};
                end
                else if (pos_reg < 5'd12)
                begin
                    source_next = {source_reg[39:0], data_byte};
                end
                else if (pos_reg < 5'd14)
                begin
                    type_next = {type_reg[7:0], data_byte};
                    if (pos_reg == 5'd13 && (type_next == port_tpid_reg ||
                        type_next == Tpid8021q || type_next == stag_tpid_reg))
                    begin
                        tags_next  = TAGS_SINGLE;
                        otpid_next = type_next;
                    end
                end
                else if (pos_reg < 5'd16 && tags_reg != TAGS_NONE)
                begin
                    otci_next = {otci_reg[7:0], data_byte};
                end
                else if (pos_reg < 5'd18 && tags_reg != TAGS_NONE)
                begin
                    type_next = {type_reg[7:0], data_byte};
                    if (pos_reg == 5'd17 && type_next == Tpid8021q)
                    begin
                        tags_next  = TAGS_DOUBLE;
                        itpid_next = type_next;
                    end
                end
                else if (pos_reg < 5'd20 && tags_reg == TAGS_DOUBLE)
                begin
                    itci_next = {itci_reg[7:0], data_byte};
                end
                else if (pos_reg < 5'd22 && tags_reg == TAGS_DOUBLE)
                begin
                    type_next = {type_reg[7:0], data_byte};
                end
                else
                begin
                    payload_next = {payload_reg[15:0], data_byte};
                end

                unique case (tags_next)
                    TAGS_NONE:   hdr_len = HdrLenUntagged;
                    TAGS_SINGLE: hdr_len = HdrLenSingle;
                    TAGS_DOUBLE: hdr_len = HdrLenDouble;
                    default:     hdr_len = HdrLenDouble;
                endcase

                if (pos_plus >= {1'b0, hdr_len})
                begin
                    llc        = type_next < LlcLimit;
                    got        = pos_plus - {1'b0, hdr_len};
                    got_enough = llc ? (got >= 6'd3) : (got >= 6'd1);
                    if (got_enough || last_byte)
                    begin
                        emit      = 1'b1;
                        sent_next = 1'b1;
                        // For LLC at most three payload bytes are held here,
                        // so the low two bits of the count are enough.
                        unique case (got[1:0])
                            2'd0:    payload_full = '0;
                            2'd1:    payload_full = {payload_next[7:0], 16'h0000};
                            2'd2:    payload_full = {payload_next[15:0], 8'h00};
                            default: payload_full = payload_next;
                        endcase
                        result_next.dest_mac   = dest_next;
                        result_next.source_mac = source_next;
                        if (llc)
                        begin
                            result_next.ether_type = payload_full[23:8];
                            result_next.sub_type   = payload_full[7:0];
                        end
                        else
                        begin
                            result_next.ether_type = type_next;
                            result_next.sub_type   = (got >= 6'd1) ? payload_next[7:0] : 8'h00;
                        end
                        if (tags_next != TAGS_NONE)
                        begin
                            result_next.outer_vid    = otci_next[11:0];
                            result_next.priority_res = otci_next[15:13];
                            result_next.outer_tpid   = otpid_next;
                        end
                        if (tags_next == TAGS_DOUBLE)
                        begin
                            result_next.inner_vid  = itci_next[11:0];
                            result_next.inner_tpid = itpid_next;
                        end
                        result_next.header_length = hdr_len;
                        result_next.status = got_enough ? STATUS_OK : STATUS_SHORT_PAYLOAD;
                    end
                end
                else if (last_byte)
                begin
                    emit               = 1'b1;
                    sent_next          = 1'b1;
                    result_next.status = STATUS_SHORT_HEADER;
                end
            end

            if (pos_reg != PosMax)
            begin
                pos_next = pos_reg + 5'd1;
            end

            // The last byte returns all frame state to its reset value.
            if (last_byte)
            begin
                pos_next     = '0;
                sent_next    = 1'b0;
                dest_next    = '0;
                source_next  = '0;
                type_next    = '0;
                otci_next    = '0;
                otpid_next   = '0;
                itci_next    = '0;
                itpid_next   = '0;
                tags_next    = TAGS_NONE;
                payload_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_tpid_reg <= PortTpidReset;
            stag_tpid_reg <= StagTpidReset;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PORT_TPID: port_tpid_reg <= cfg_data;
                REG_STAG_TPID: stag_tpid_reg <= cfg_data;
                default:       port_tpid_reg <= port_tpid_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            sent_reg      <= 1'b0;
            dest_reg      <= '0;
            source_reg    <= '0;
            type_reg      <= '0;
            otci_reg      <= '0;
            otpid_reg     <= '0;
            itci_reg      <= '0;
            itpid_reg     <= '0;
            tags_reg      <= TAGS_NONE;
            payload_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            sent_reg    <= sent_next;
            dest_reg    <= dest_next;
            source_reg  <= source_next;
            type_reg    <= type_next;
            otci_reg    <= otci_next;
            otpid_reg   <= otpid_next;
            itci_reg    <= itci_next;
            itpid_reg   <= itpid_next;
            tags_reg    <= tags_next;
            payload_reg <= payload_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid  = out_valid_reg;
    assign dest_mac      = result_reg.dest_mac;
    assign source_mac    = result_reg.source_mac;
    assign ether_type    = result_reg.ether_type;
    assign sub_type      = result_reg.sub_type;
    assign outer_vid     = result_reg.outer_vid;
    assign priority_res  = result_reg.priority_res;
    assign outer_tpid    = result_reg.outer_tpid;
    assign inner_vid     = result_reg.inner_vid;
    assign inner_tpid    = result_reg.inner_tpid;
    assign header_length = result_reg.header_length;
    assign status        = result_reg.status;

endmodule

>>> verif/evhp_checker.sv
// Checker for the Ethernet VLAN header parser: predicts each parse result and compares it.
module evhp_checker
    import evhp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data,
    input  logic                     byte_valid,
    input  logic                     byte_ready,
    input  logic [7:0]               data_byte,
    input  logic                     last_byte,
    input  logic                     result_valid,
    input  logic                     result_ready,
    input  logic [47:0]              dest_mac,
    input  logic [47:0]              source_mac,
    input  logic [15:0]              ether_type,
    input  logic [7:0]               sub_type,
    input  logic [11:0]              outer_vid,
    input  logic [2:0]               priority_res,
    input  logic [15:0]              outer_tpid,
    input  logic [11:0]              inner_vid,
    input  logic [15:0]              inner_tpid,
    input  logic [4:0]               header_length,
    input  logic [1:0]               status,
    output int                       mismatch_count,
    output int                       outstanding,
    output int                       results_checked
);

    logic [15:0] port_tpid_r;
    logic [15:0] stag_tpid_r;

    logic [4:0]  byte_pos;
    logic        frame_done;
    logic [47:0] dest_sr;
    logic [47:0] src_sr;
    logic [15:0] type_sr;
    logic [15:0] outer_tci_r;
    logic [15:0] outer_tpid_r;
    logic [15:0] inner_tci_r;
    logic [15:0] inner_tpid_r;
    tag_count_t  tags;
    logic [23:0] pay_sr;

    result_t     pending_headers[$];
    int          err_count;
    int          checked;

    task automatic clear_frame();
        byte_pos     = '0;
        frame_done   = 1'b0;
        dest_sr      = '0;
        src_sr       = '0;
        type_sr      = '0;
        outer_tci_r  = '0;
        outer_tpid_r = '0;
        inner_tci_r  = '0;
        inner_tpid_r = '0;
        tags         = TAGS_NONE;
        pay_sr       = '0;
    endtask

    // Advances the header parse by one byte and queues the result it completes, if any.
    task automatic parse_byte(input logic [7:0] b, input logic lst);
        result_t     r;
        int          pos_i;
        int          hdr_len;
        int          got;
        int          need;
        logic        llc;
        logic [23:0] full;
        pos_i = int'(byte_pos);
        if (!frame_done)
        begin
            if (pos_i < 6)
                dest_sr = {dest_sr[39:0], b};
            else if (pos_i < 12)
                src_sr = {src_sr[39:0], b};
            else if (pos_i < 14)
            begin
                type_sr = {type_sr[7:0], b};
                if (pos_i == 13 && (type_sr == port_tpid_r || type_sr == Tpid8021q
                                    || type_sr == stag_tpid_r))
                begin
                    tags         = TAGS_SINGLE;
                    outer_tpid_r = type_sr;
                end
            end
            else if (pos_i < 16 && tags != TAGS_NONE)
                outer_tci_r = {outer_tci_r[7:0], b};
            else if (pos_i < 18 && tags != TAGS_NONE)
            begin
                type_sr = {type_sr[7:0], b};
                if (pos_i == 17 && type_sr == Tpid8021q)
                begin
                    tags         = TAGS_DOUBLE;
                    inner_tpid_r = type_sr;
                end
            end
            else if (pos_i < 20 && tags == TAGS_DOUBLE)
                inner_tci_r = {inner_tci_r[7:0], b};
            else if (pos_i < 22 && tags == TAGS_DOUBLE)
                type_sr = {type_sr[7:0], b};
            else
                pay_sr = {pay_sr[15:0], b};

            hdr_len = 14 + 4 * int'(tags);
            r = '0;
            if (pos_i + 1 >= hdr_len)
            begin
                llc  = (type_sr < LlcLimit);
                need = llc ? 3 : 1;
                got  = pos_i + 1 - hdr_len;
                if (got >= need || lst)
                begin
                    r.dest_mac   = dest_sr;
                    r.source_mac = src_sr;
                    r.ether_type = type_sr;
                    // LLC frames take type and subtype from the payload; missing
                    // bytes read as zero, so the bytes present sit at the top.
                    if (llc)
                    begin
                        full         = pay_sr << (8 * (3 - got));
                        r.ether_type = full[23:8];
                        r.sub_type   = full[7:0];
                    end
                    else if (got >= 1)
                        r.sub_type = pay_sr[7:0];
                    if (tags != TAGS_NONE)
                    begin
                        r.outer_vid    = outer_tci_r[11:0];
                        r.priority_res = outer_tci_r[15:13];
                        r.outer_tpid   = outer_tpid_r;
                    end
                    if (tags == TAGS_DOUBLE)
                    begin
                        r.inner_vid  = inner_tci_r[11:0];
                        r.inner_tpid = inner_tpid_r;
                    end
                    r.header_length = 5'(hdr_len);
                    r.status        = (got >= need) ? STATUS_OK : STATUS_SHORT_PAYLOAD;
                    pending_headers.push_back(r);
                    frame_done = 1'b1;
                end
            end
            else if (lst)
            begin
                r.header_length = HdrLenUntagged;
                r.status        = STATUS_SHORT_HEADER;
                pending_headers.push_back(r);
                frame_done = 1'b1;
            end
        end
        if (byte_pos != PosMax)
            byte_pos = byte_pos + 5'd1;
        if (lst)
            clear_frame();
    endtask

    function automatic void check_field(input string name, input logic [47:0] want,
                                        input logic [47:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            port_tpid_r = PortTpidReset;
            stag_tpid_r = StagTpidReset;
            clear_frame();
            pending_headers.delete();
            err_count = 0;
            checked   = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_PORT_TPID: port_tpid_r = cfg_data;
                    REG_STAG_TPID: stag_tpid_r = cfg_data;
                    default: ;
                endcase
            end
            // A result is registered, so the one leaving now belongs to an earlier byte.
            if (result_valid && result_ready)
            begin
                if (pending_headers.size() == 0)
                begin
                    $error("result transfer with no parse result expected");
                    err_count++;
                end
                else
                begin
                    want = pending_headers.pop_front();
                    check_field("dest_mac", want.dest_mac, dest_mac);
                    check_field("source_mac", want.source_mac, source_mac);
                    check_field("ether_type", 48'(want.ether_type), 48'(ether_type));
                    check_field("sub_type", 48'(want.sub_type), 48'(sub_type));
                    check_field("outer_vid", 48'(want.outer_vid), 48'(outer_vid));
                    check_field("priority_res", 48'(want.priority_res), 48'(priority_res));
                    check_field("outer_tpid", 48'(want.outer_tpid), 48'(outer_tpid));
                    check_field("inner_vid", 48'(want.inner_vid), 48'(inner_vid));
                    check_field("inner_tpid", 48'(want.inner_tpid), 48'(inner_tpid));
                    check_field("header_length", 48'(want.header_length),
                                48'(header_length));
                    check_field("status", 48'(want.status), 48'(status));
                    checked++;
                end
            end
            if (byte_valid && byte_ready)
                parse_byte(data_byte, last_byte);
        end
        mismatch_count  <= err_count;
        outstanding     <= pending_headers.size();
        results_checked <= checked;
    end

endmodule

>>> verif/tb_top.sv
// Top of the header parser testbench: clock, reset, frame stimulus and the verdict.
module tb_top
    import evhp_pkg::*;
();

    localparam int NumPhases     = 6;
    localparam int BytesPerPhase = 200;

    logic                     clk;
    logic                     rst_n        = 1'b0;
    logic                     cfg_write    = 1'b0;
    logic [CfgIndexWidth-1:0] cfg_index    = '0;
    logic [CfgDataWidth-1:0]  cfg_data     = '0;
    logic                     byte_valid   = 1'b0;
    logic                     byte_ready;
    logic [7:0]               data_byte    = 8'h00;
    logic                     last_byte    = 1'b0;
    logic                     result_valid;
    logic                     result_ready = 1'b0;
    logic [47:0]              dest_mac;
    logic [47:0]              source_mac;
    logic [15:0]              ether_type;
    logic [7:0]               sub_type;
    logic [11:0]              outer_vid;
    logic [2:0]               priority_res;
    logic [15:0]              outer_tpid;
    logic [11:0]              inner_vid;
    logic [15:0]              inner_tpid;
    logic [4:0]               header_length;
    logic [1:0]               status;
    int                       mismatch_count;
    int                       outstanding;
    int                       results_checked;

    logic [7:0]  frame_q[$];
    logic [15:0] port_cur;
    logic [15:0] stag_cur;
    int          burst_left  = 0;
    int          bytes_sent  = 0;
    int          frames_sent = 0;

    ethernet_vlan_header_parser i_dut (.*);

    evhp_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    // Receiver: stretches of steady, random, mostly stalled and mostly open ready, plus a long
    // hold-off now and then so that the result register backs up into the input.
    initial
    begin
        int cyc;
        int next_hold;
        int seg;
        int mode;
        cyc       = 0;
        next_hold = 1200;
        forever
        begin
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(4, 40);
            if (cyc >= next_hold)
            begin
                result_ready <= 1'b0;
                repeat (300) @(posedge clk);
                cyc       += 300;
                next_hold += 6000;
            end
            repeat (seg)
            begin
                case (mode)
                    0:       result_ready <= 1'b1;
                    1:       result_ready <= 1'($urandom);
                    2:       result_ready <= ($urandom_range(0, 3) == 0);
                    default: result_ready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge clk);
                cyc++;
            end
        end
    end

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [15:0] pick_type();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 16'($urandom_range(0, 1535));
            4:
            begin
                case ($urandom_range(0, 4))
                    0:       return 16'h0000;
                    1:       return LlcLimit - 16'd1;
                    2:       return LlcLimit;
                    3:       return Tpid8021q;
                    default: return 16'hFFFF;
                endcase
            end
            default: return 16'($urandom_range(1536, 65535));
        endcase
    endfunction

    task automatic push16(input logic [15:0] w);
        frame_q.push_back(w[15:8]);
        frame_q.push_back(w[7:0]);
    endtask

    task automatic make_frame(input logic [47:0] da, input logic [47:0] sa, input int tags,
                              input logic [15:0] otype, input logic [15:0] otci,
                              input logic [15:0] itci, input logic [15:0] ftype,
                              input int pay_len);
        frame_q.delete();
        for (int i = 5; i >= 0; i--)
            frame_q.push_back(da[8*i +: 8]);
        for (int i = 5; i >= 0; i--)
            frame_q.push_back(sa[8*i +: 8]);
        if (tags >= 1)
        begin
            push16(otype);
            push16(otci);
        end
        if (tags == 2)
        begin
            push16(Tpid8021q);
            push16(itci);
        end
        push16(ftype);
        repeat (pay_len) frame_q.push_back(8'($urandom));
    endtask

    task automatic trim_frame(input int len);
        while (frame_q.size() > len)
            void'(frame_q.pop_back());
    endtask

    // Offers one byte; the sender runs in bursts with random gaps between them.
    task automatic send_byte(input logic [7:0] b, input logic lst);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if ($urandom_range(0, 19) == 0)
                gap = 20;
            if (gap > 0)
            begin
                byte_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        byte_valid <= 1'b1;
        data_byte  <= b;
        last_byte  <= lst;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i], i == frame_q.size() - 1);
        frames_sent++;
    endtask

    task automatic random_frame();
        int          kind;
        int          tags;
        int          pay_len;
        logic [15:0] otype;
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            frame_q.delete();
            repeat ($urandom_range(1, 40)) frame_q.push_back(8'($urandom));
        end
        else
        begin
            tags = (kind < 3) ? 0 : (kind < 6) ? 1 : 2;
            case ($urandom_range(0, 2))
                0:       otype = port_cur;
                1:       otype = Tpid8021q;
                default: otype = stag_cur;
            endcase
            pay_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 6);
            make_frame(rand48(), rand48(), tags, otype, 16'($urandom), 16'($urandom),
                       pick_type(), pay_len);
            if ($urandom_range(0, 5) == 0)
                trim_frame($urandom_range(1, frame_q.size()));
        end
        send_frame();
    endtask

    // The sender stops until every expected result has been seen, then lets the
    // result register settle.
    task automatic wait_idle();
        byte_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_tpids(input logic [15:0] p, input logic [15:0] s);
        cfg_write <= 1'b1;
        cfg_index <= REG_PORT_TPID;
        cfg_data  <= p;
        @(posedge clk);
        cfg_index <= REG_STAG_TPID;
        cfg_data  <= s;
        @(posedge clk);
        cfg_write <= 1'b0;
        port_cur = p;
        stag_cur = s;
    endtask

    initial
    begin
        int          phase;
        int          phase_start;
        logic [15:0] p;
        logic [15:0] s;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (phase = 0; phase < NumPhases; phase++)
        begin
            case (phase)
                0:
                begin
                    p = 16'h9100;
                    s = StagTpidReset;
                end
                1:
                begin
                    p = 16'h0000;
                    s = 16'hFFFF;
                end
                2:
                begin
                    p = 16'hFFFF;
                    s = 16'h0000;
                end
                3:
                begin
                    p = PortTpidReset;
                    s = StagTpidReset;
                end
                4:
                begin
                    p = 16'h05FF;
                    s = Tpid8021q;
                end
                default:
                begin
                    p = 16'($urandom);
                    s = 16'($urandom);
                end
            endcase
            program_tpids(p, s);
            if (phase == 0)
            begin
                // MAC extremes, each header shape, both sides of the LLC boundary, truncation in
                // the destination MAC, in a type field and after a tag, and a frame past saturation.
                make_frame(48'hFFFF_FFFF_FFFF, 48'h0, 0, '0, '0, '0, 16'h0800, 1);
                send_frame();
                make_frame(48'h0, 48'hFFFF_FFFF_FFFF, 0, '0, '0, '0, 16'h0800, 0);
                send_frame();
                make_frame(rand48(), rand48(), 0, '0, '0, '0, 16'h0800, 4);
                trim_frame(1);
                send_frame();
                make_frame(rand48(), rand48(), 0, '0, '0, '0, 16'h0800, 4);
                trim_frame(13);
                send_frame();
                make_frame(rand48(), rand48(), 0, '0, '0, '0, 16'd1500, 5);
                send_frame();
                make_frame(rand48(), rand48(), 0, '0, '0, '0, LlcLimit - 16'd1, 1);
                send_frame();
                make_frame(rand48(), rand48(), 0, '0, '0, '0, LlcLimit, 2);
                send_frame();
                make_frame(rand48(), rand48(), 1, Tpid8021q, 16'hFFFF, '0, 16'h86DD, 1);
                send_frame();
                make_frame(rand48(), rand48(), 1, port_cur, 16'h0000, '0, 16'hFFFF, 1);
                send_frame();
                make_frame(rand48(), rand48(), 2, stag_cur, 16'hE001, 16'h0FFF, 16'h0000, 3);
                send_frame();
                make_frame(rand48(), rand48(), 1, Tpid8021q, 16'h2345, '0, 16'h0800, 2);
                trim_frame(16);
                send_frame();
                make_frame(rand48(), rand48(), 2, Tpid8021q, 16'h6789, 16'h0ABC, 16'h0800, 2);
                trim_frame(21);
                send_frame();
                make_frame(rand48(), rand48(), 2, port_cur, 16'hA5A5, 16'h5A5A, 16'h0040, 0);
                send_frame();
                make_frame(rand48(), rand48(), 1, stag_cur, 16'h1FFF, '0, 16'h0800, 30);
                send_frame();
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < BytesPerPhase)
                random_frame();
            wait_idle();
        end
        repeat (10) @(posedge clk);
        $display("Sent %0d frames (%0d bytes) under %0d TPID settings; %0d results compared.",
                 frames_sent, bytes_sent, NumPhases, results_checked);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> sim.f
sv/evhp_pkg.sv
sv/ethernet_vlan_header_parser.sv
verif/evhp_checker.sv
verif/tb_top.sv
